// ===== design/awe_pkg.sv =====
`timescale 1ns / 1ps
// awe_pkg: shared constants for the aroon window extreme age block
// no dependencies

package awe_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] LEN_RESET = 7'd14;

  localparam int PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam int STEP_W = $clog2(PCT_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PCT_W - 1);

endpackage

// ===== design/awe_cell.sv =====
`timescale 1ns / 1ps
// awe_cell: one slot of the close shift chain plus one stage of the extreme scan wave
// no package dependencies

module awe_cell #(
  parameter int PRICE_BITS = 32,
  parameter int LEN_W = 7,
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic [PRICE_BITS-1:0] price_i,
  output logic [PRICE_BITS-1:0] price_o,
  input  logic [LEN_W-1:0]      fill_i,
  input  logic                  have_i,
  input  logic [PRICE_BITS-1:0] max_val_i,
  input  logic [LEN_W-1:0]      max_age_i,
  input  logic [PRICE_BITS-1:0] min_val_i,
  input  logic [LEN_W-1:0]      min_age_i,
  output logic                  have_o,
  output logic [PRICE_BITS-1:0] max_val_o,
  output logic [LEN_W-1:0]      max_age_o,
  output logic [PRICE_BITS-1:0] min_val_o,
  output logic [LEN_W-1:0]      min_age_o
);

  localparam logic [LEN_W-1:0] MY_AGE = LEN_W'(IDX);

  logic [PRICE_BITS-1:0] price_q;
  logic                  have_q;
  logic [PRICE_BITS-1:0] max_val_q, min_val_q;
  logic [LEN_W-1:0]      max_age_q, min_age_q;
  logic                  in_win, take_max, take_min;

  assign in_win   = MY_AGE < fill_i;
  // newer entry wins ties, the wave runs from old to new
  assign take_max = in_win && (!have_i || (price_q >= max_val_i));
  assign take_min = in_win && (!have_i || (price_q <= min_val_i));

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      price_q <= price_i;
    end
    max_val_q <= take_max ? price_q : max_val_i;
    max_age_q <= take_max ? MY_AGE : max_age_i;
    min_val_q <= take_min ? price_q : min_val_i;
    min_age_q <= take_min ? MY_AGE : min_age_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_i | in_win;
    end
  end

  assign price_o   = price_q;
  assign have_o    = have_q;
  assign max_val_o = max_val_q;
  assign max_age_o = max_age_q;
  assign min_val_o = min_val_q;
  assign min_age_o = min_age_q;

endmodule

// ===== design/awe_div.sv =====
`timescale 1ns / 1ps
// awe_div: restoring divider for floor((len - age) * 100 / len), one quotient bit a cycle
// depends on awe_pkg

module awe_div import awe_pkg::*; #(
  parameter int LEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic [LEN_W-1:0] age_i,
  output logic [PCT_W-1:0] pct_o,
  output logic             done_o
);

  localparam int NUM_W = LEN_W + PCT_W;

  logic [NUM_W-1:0]  rem_q, div_q;
  logic [PCT_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [LEN_W-1:0]  diff;
  logic              ge;

  assign diff = len_i - age_i;
  assign ge   = rem_q >= div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= NUM_W'(diff) * NUM_W'(PCT_FULL);
      div_q  <= NUM_W'(len_i) << (PCT_W - 1);
      quo_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= ge ? (rem_q - div_q) : rem_q;
      div_q  <= div_q >> 1;
      quo_q  <= {quo_q[PCT_W-2:0], ge};
      step_q <= step_q + 1'b1;
      if (step_q == STEP_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign pct_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== design/aroon_window_extreme_age.sv =====
`timescale 1ns / 1ps
// aroon_window_extreme_age: aroon up/down over a sliding window of closes
// depends on awe_pkg, awe_cell, awe_div
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, close_price_i, time_stamp_i | item in
//   out     | out_valid_o/out_ready_i, aroon_up_o, aroon_down_o, out_time_o | item out
//   cfg     | cfg_valid_i/cfg_ready_o, window_length_i  | register write
//
// one item at a time: the next item is taken only after the result has moved to the output
// register; the result comes from the 7-step percent divider;
// when an extreme leaves the window a scan wave runs down the cell chain,
// before the divide starts.
// reset empties the window and sets the length to 14; no clearing pass.
// a length write is taken only while idle and goes ahead of an item offered with it.
// a held result in the output register does not block the next item's intake.

module aroon_window_extreme_age import awe_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      close_price_i,
  input  logic [31:0]      time_stamp_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PCT_W-1:0] aroon_up_o,
  output logic [PCT_W-1:0] aroon_down_o,
  output logic [31:0]      out_time_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] window_length_i
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_HOLD} state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      len_q;
  logic [LEN_W-1:0]      fill_q, cnt_q;
  logic [PRICE_BITS-1:0] max_q, min_q;
  logic [LEN_W-1:0]      max_age_q, min_age_q;
  logic                  scan_max_q, scan_min_q, start_q;
  logic [31:0]           time_q;
  logic                  out_valid_q;
  logic [PCT_W-1:0]      up_q, dn_q;
  logic [31:0]           otime_q;

  logic                  in_acc, cfg_acc, out_free, div_done;
  logic [CMP_W-1:0]      len_x, n_x;
  logic [LEN_W-1:0]      n, fill_d, max_age_inc, min_age_inc, am, an;
  logic [PRICE_BITS-1:0] p;
  logic [PCT_W-1:0]      up_pct, dn_pct;
  logic                  up_done, dn_done;

  logic [PRICE_BITS-1:0] chain_price [WINDOW_MAX];
  logic                  wave_have [WINDOW_MAX+1];
  logic [PRICE_BITS-1:0] wave_max [WINDOW_MAX+1];
  logic [PRICE_BITS-1:0] wave_min [WINDOW_MAX+1];
  logic [LEN_W-1:0]      wave_max_age [WINDOW_MAX+1];
  logic [LEN_W-1:0]      wave_min_age [WINDOW_MAX+1];

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign div_done    = up_done & dn_done;

  assign p = PRICE_BITS'(close_price_i);

  always_comb begin
    len_x = CMP_W'(len_q);
    n_x   = len_x;
    if (len_x == '0) begin
      n_x = CMP_W'(1);
    end else if (len_x > CMP_W'(WINDOW_MAX)) begin
      n_x = CMP_W'(WINDOW_MAX);
    end
    n = n_x[LEN_W-1:0];
  end

  assign fill_d      = (fill_q < n) ? (fill_q + 1'b1) : fill_q;
  assign max_age_inc = max_age_q + 1'b1;
  assign min_age_inc = min_age_q + 1'b1;
  assign am          = (max_age_q < n) ? max_age_q : (n - 1'b1);
  assign an          = (min_age_q < n) ? min_age_q : (n - 1'b1);

  // scan wave enters above the oldest cell empty
  assign wave_have[WINDOW_MAX]    = 1'b0;
  assign wave_max[WINDOW_MAX]     = '0;
  assign wave_min[WINDOW_MAX]     = '0;
  assign wave_max_age[WINDOW_MAX] = '0;
  assign wave_min_age[WINDOW_MAX] = '0;
  assign chain_price[0]           = p;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k < WINDOW_MAX - 1) begin : g_mid
      awe_cell #(
        .PRICE_BITS (PRICE_BITS),
        .LEN_W      (LEN_W),
        .IDX        (k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (in_acc),
        .price_i   (chain_price[k]),
        .price_o   (chain_price[k+1]),
        .fill_i    (fill_q),
        .have_i    (wave_have[k+1]),
        .max_val_i (wave_max[k+1]),
        .max_age_i (wave_max_age[k+1]),
        .min_val_i (wave_min[k+1]),
        .min_age_i (wave_min_age[k+1]),
        .have_o    (wave_have[k]),
        .max_val_o (wave_max[k]),
        .max_age_o (wave_max_age[k]),
        .min_val_o (wave_min[k]),
        .min_age_o (wave_min_age[k])
      );
    end else begin : g_last
      awe_cell #(
        .PRICE_BITS (PRICE_BITS),
        .LEN_W      (LEN_W),
        .IDX        (k)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (in_acc),
        .price_i   (chain_price[k]),
        .price_o   (),
        .fill_i    (fill_q),
        .have_i    (wave_have[k+1]),
        .max_val_i (wave_max[k+1]),
        .max_age_i (wave_max_age[k+1]),
        .min_val_i (wave_min[k+1]),
        .min_age_i (wave_min_age[k+1]),
        .have_o    (wave_have[k]),
        .max_val_o (wave_max[k]),
        .max_age_o (wave_max_age[k]),
        .min_val_o (wave_min[k]),
        .min_age_o (wave_min_age[k])
      );
    end
  end

  awe_div #(.LEN_W(LEN_W)) u_div_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .len_i   (n),
    .age_i   (am),
    .pct_o   (up_pct),
    .done_o  (up_done)
  );

  awe_div #(.LEN_W(LEN_W)) u_div_dn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .len_i   (n),
    .age_i   (an),
    .pct_o   (dn_pct),
    .done_o  (dn_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      fill_q      <= '0;
      cnt_q       <= '0;
      max_q       <= '0;
      min_q       <= '0;
      max_age_q   <= '0;
      min_age_q   <= '0;
      scan_max_q  <= 1'b0;
      scan_min_q  <= 1'b0;
      start_q     <= 1'b0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      up_q        <= '0;
      dn_q        <= '0;
      otime_q     <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            time_q     <= time_stamp_i;
            fill_q     <= fill_d;
            scan_max_q <= 1'b0;
            scan_min_q <= 1'b0;
            cnt_q      <= '0;
            if (fill_q == '0) begin
              max_q     <= p;
              min_q     <= p;
              max_age_q <= '0;
              min_age_q <= '0;
              start_q   <= 1'b1;
              state_q   <= ST_DIV;
            end else begin
              if (p >= max_q) begin
                max_q     <= p;
                max_age_q <= '0;
              end else begin
                max_age_q  <= max_age_inc;
                scan_max_q <= (max_age_inc >= fill_d);
              end
              if (p <= min_q) begin
                min_q     <= p;
                min_age_q <= '0;
              end else begin
                min_age_q  <= min_age_inc;
                scan_min_q <= (min_age_inc >= fill_d);
              end
              if ((p < max_q && max_age_inc >= fill_d) ||
                  (p > min_q && min_age_inc >= fill_d)) begin
                state_q <= ST_SCAN;
              end else begin
                start_q <= 1'b1;
                state_q <= ST_DIV;
              end
            end
          end
        end
        ST_SCAN: begin
          // wave reaches cell zero clean once cnt_q reaches WINDOW_MAX
          if (cnt_q == LEN_W'(WINDOW_MAX)) begin
            if (scan_max_q) begin
              max_q     <= wave_max[0];
              max_age_q <= wave_max_age[0];
            end
            if (scan_min_q) begin
              min_q     <= wave_min[0];
              min_age_q <= wave_min_age[0];
            end
            start_q <= 1'b1;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            up_q        <= up_pct;
            dn_q        <= dn_pct;
            otime_q     <= time_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_acc) begin
        len_q     <= window_length_i;
        fill_q    <= '0;
        max_q     <= '0;
        min_q     <= '0;
        max_age_q <= '0;
        min_age_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign aroon_up_o   = up_q;
  assign aroon_down_o = dn_q;
  assign out_time_o   = otime_q;

endmodule

// ===== verif/aroon_checker.sv =====
`timescale 1ns / 1ps
// aroon_checker: watches the item, result and length-write channels of the aroon block,
// predicts aroon up/down per item and compares each result in order
// depends on awe_pkg

module aroon_checker import awe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [31:0]      close_price_i,
  input  logic [31:0]      time_stamp_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [PCT_W-1:0] aroon_up_i,
  input  logic [PCT_W-1:0] aroon_down_i,
  input  logic [31:0]      out_time_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] window_length_i,
  output int               outstanding_o,
  output int               mismatches_o
);

  typedef struct packed {
    logic [PCT_W-1:0] up;
    logic [PCT_W-1:0] down;
    logic [31:0]      stamp;
  } aroon_result_t;

  logic [31:0]      close_hist [WINDOW_MAX_DEF];
  logic [CFG_W-1:0] length_reg;
  int unsigned      next_slot;
  int unsigned      filled;
  logic [31:0]      high_val;
  int unsigned      high_age;
  logic [31:0]      low_val;
  int unsigned      low_age;
  aroon_result_t    aroon_expected_q [$];
  aroon_result_t    oldest;
  int               errors = 0;

  function automatic int unsigned active_length();
    if (length_reg == '0) return 1;
    if (length_reg > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
    return length_reg;
  endfunction

  function automatic void empty_window();
    next_slot = 0;
    filled    = 0;
    high_val  = '0;
    high_age  = 0;
    low_val   = '0;
    low_age   = 0;
  endfunction

  // oldest to newest, so on equal prices the newer entry wins
  function automatic void rescan_extreme(input bit want_high, input int unsigned newest,
                                         input int unsigned n, output logic [31:0] best,
                                         output int unsigned best_age);
    bit          found;
    int unsigned k;
    int unsigned age;
    logic [31:0] v;
    found    = 1'b0;
    best     = '0;
    best_age = 0;
    for (k = filled; k > 0; k--) begin
      age = k - 1;
      v = close_hist[(newest + n - age) % n];
      if (!found || (want_high ? (v >= best) : (v <= best))) begin
        best     = v;
        best_age = age;
        found    = 1'b1;
      end
    end
  endfunction

  function automatic logic [PCT_W-1:0] age_percent(input int unsigned age,
                                                   input int unsigned n);
    int unsigned a;
    a = (age < n) ? age : n - 1;
    return PCT_W'(((n - a) * int'(PCT_FULL)) / n);
  endfunction

  function automatic aroon_result_t predict_aroon(input logic [31:0] price,
                                                  input logic [31:0] stamp);
    aroon_result_t r;
    int unsigned   n;
    int unsigned   slot;
    bit            first_item;
    n          = active_length();
    slot       = next_slot % n;
    first_item = (filled == 0);
    close_hist[slot] = price;
    next_slot = (slot + 1 >= n) ? 0 : slot + 1;
    if (filled < n) filled++;
    if (filled > n) filled = n;
    if (first_item) begin
      high_val = price;
      high_age = 0;
      low_val  = price;
      low_age  = 0;
    end else begin
      if (price >= high_val) begin
        high_val = price;
        high_age = 0;
      end else begin
        high_age++;
        if (high_age >= filled) rescan_extreme(1'b1, slot, n, high_val, high_age);
      end
      if (price <= low_val) begin
        low_val = price;
        low_age = 0;
      end else begin
        low_age++;
        if (low_age >= filled) rescan_extreme(1'b0, slot, n, low_val, low_age);
      end
    end
    r.up    = age_percent(high_age, n);
    r.down  = age_percent(low_age, n);
    r.stamp = stamp;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_reg = LEN_RESET;
      empty_window();
      aroon_expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        length_reg = window_length_i;
        empty_window();
      end
      if (in_valid_i && in_ready_i) begin
        aroon_expected_q.push_back(predict_aroon(close_price_i, time_stamp_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (aroon_expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual up %0d down %0d time %h",
                   $time, aroon_up_i, aroon_down_i, out_time_i);
        end else begin
          oldest = aroon_expected_q.pop_front();
          if (aroon_up_i !== oldest.up) begin
            errors++;
            $display("%0t: aroon_up expected %0d actual %0d", $time, oldest.up, aroon_up_i);
          end
          if (aroon_down_i !== oldest.down) begin
            errors++;
            $display("%0t: aroon_down expected %0d actual %0d", $time, oldest.down,
                     aroon_down_i);
          end
          if (out_time_i !== oldest.stamp) begin
            errors++;
            $display("%0t: out_time expected %h actual %h", $time, oldest.stamp, out_time_i);
          end
        end
      end
    end
    outstanding_o = aroon_expected_q.size();
    mismatches_o  = errors;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives price items and window length writes into aroon_window_extreme_age
// with random idling on both sides; depends on awe_pkg, aroon_checker and the block

module testbench;
  import awe_pkg::*;

  localparam int unsigned ITEM_TOTAL  = 1400;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef enum int {
    MODE_SPREAD,
    MODE_TIES,
    MODE_RISE,
    MODE_FALL,
    MODE_RAILS,
    MODE_WANDER
  } price_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [31:0]      close_price = '0;
  logic [31:0]      time_stamp = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PCT_W-1:0] aroon_up;
  logic [PCT_W-1:0] aroon_down;
  logic [31:0]      out_time;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] window_length = '0;

  int               outstanding;
  int               mismatches;
  int unsigned      cycle_count = 0;
  int unsigned      stall_left = 0;
  bit               calm = 1'b0;

  price_mode_e      trend_mode = MODE_SPREAD;
  int unsigned      trend_left = 0;
  logic [31:0]      prev_price = '0;
  logic [31:0]      stamp = '0;

  logic [31:0] edge_prices [22] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
    32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5,
    32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd5, 32'd5
  };
  logic [CFG_W-1:0] fixed_lengths [7] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd63};

  aroon_window_extreme_age dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .close_price_i  (close_price),
    .time_stamp_i   (time_stamp),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .aroon_up_o     (aroon_up),
    .aroon_down_o   (aroon_down),
    .out_time_o     (out_time),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .window_length_i(window_length)
  );

  aroon_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .close_price_i  (close_price),
    .time_stamp_i   (time_stamp),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .aroon_up_i     (aroon_up),
    .aroon_down_i   (aroon_down),
    .out_time_i     (out_time),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .window_length_i(window_length),
    .outstanding_o  (outstanding),
    .mismatches_o   (mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL aroon_window_extreme_age");
      $finish;
    end
  end

  // receiver stalls at random, in bursts, while not calm
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_price();
    logic [31:0] p;
    if (trend_left == 0) begin
      trend_mode = price_mode_e'($urandom_range(0, int'(MODE_WANDER)));
      trend_left = $urandom_range(1, 90);
    end
    trend_left--;
    case (trend_mode)
      MODE_SPREAD: p = $urandom();
      MODE_TIES:   p = $urandom_range(0, 3);
      MODE_RISE:   p = prev_price + $urandom_range(0, 7);
      MODE_FALL:   p = prev_price - $urandom_range(0, 7);
      MODE_RAILS:  p = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default:     p = prev_price + $urandom_range(0, 31) - 16;
    endcase
    prev_price = p;
    return p;
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic send_item(input logic [31:0] price, input logic [31:0] ts);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    close_price <= price;
    time_stamp  <= ts;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    wait_drained();
    cfg_valid     <= 1'b1;
    window_length <= len;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] len;
    int unsigned      sent;
    int unsigned      quota;
    int unsigned      ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rails, ties and extremes expiring, at the reset length
    foreach (edge_prices[i]) begin
      send_item(edge_prices[i], (i == 1) ? 32'hFFFF_FFFF : 32'(i));
    end
    in_valid <= 1'b0;
    sent = $size(edge_prices);
    ph = 0;

    while (sent < ITEM_TOTAL) begin
      calm = (sent + 150 >= ITEM_TOTAL) || ($urandom_range(0, 3) == 0);
      if (ph < $size(fixed_lengths)) len = fixed_lengths[ph];
      else if ($urandom_range(0, 7) == 0) len = CFG_W'($urandom_range(0, 127));
      else len = CFG_W'($urandom_range(1, 64));
      write_length(len);
      trend_left = 0;
      quota = $urandom_range(80, 160);
      if (quota > ITEM_TOTAL - sent) quota = ITEM_TOTAL - sent;
      repeat (quota) begin
        if (sent + 150 >= ITEM_TOTAL) calm = 1'b1;
        stamp = ($urandom_range(0, 15) == 0) ? $urandom() : stamp + $urandom_range(1, 1000);
        send_item(pick_price(), stamp);
        sent++;
      end
      in_valid <= 1'b0;
      ph++;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS aroon_window_extreme_age");
    end else begin
      $display("FAIL aroon_window_extreme_age");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/awe_pkg.sv
design/awe_cell.sv
design/awe_div.sv
design/aroon_window_extreme_age.sv
verif/aroon_checker.sv
verif/testbench.sv
